@@ rtl/core/ijtc_pkg.sv @@
`default_nettype none

package ijtc_pkg;

  localparam int MAX_INDEX_BITS_DEFAULT = 10;

  localparam int PC_W     = 32;
  localparam int WORD_W   = 32;
  localparam int OFFSET_W = 24;
  localparam int COUNT_W  = 40;
  localparam int MARKER_W = 8;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CACHE_MODE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INDEX_WIDTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HASH_ENABLE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MARKER_BYTE = 2'd3;
  localparam int CFG_DATA_W = 8;

  // cache modes; the fourth code behaves as MODE_COUNT
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_TABLE  = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;

  localparam logic [1:0] RESET_CACHE_MODE  = MODE_TABLE;
  localparam logic [3:0] RESET_INDEX_WIDTH = 4'd10;
  localparam logic       RESET_HASH_ENABLE = 1'b1;
  localparam logic [7:0] RESET_MARKER_BYTE = 8'd104;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic                valid;
    logic [PC_W-1:0]     tag;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/ijtc_in_if.sv @@
`default_nettype none

interface ijtc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ijtc_pkg::PC_W-1:0]   jump_pc;
  logic [ijtc_pkg::WORD_W-1:0] memory_word;

  modport source (output valid, jump_pc, memory_word, input ready);
  modport sink   (input valid, jump_pc, memory_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ijtc_out_if.sv @@
`default_nettype none

interface ijtc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          table_hit;
  logic                          block_found;
  logic [ijtc_pkg::OFFSET_W-1:0] block_offset;
  logic [ijtc_pkg::COUNT_W-1:0]  hits_so_far;
  logic [ijtc_pkg::COUNT_W-1:0]  misses_so_far;

  modport source (output valid, table_hit, block_found, block_offset, hits_so_far,
                  misses_so_far, input ready);
  modport sink   (input valid, table_hit, block_found, block_offset, hits_so_far,
                  misses_so_far, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ijtc_ram.sv @@
`default_nettype none

module ijtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/indirect_jump_target_cache.sv @@
// Channel   Dir  Fields                                          Handshake
// in_ch     in   jump_pc, memory_word                            valid/ready
// out_ch    out  table_hit, block_found, block_offset,           valid/ready
//                hits_so_far, misses_so_far
// cfg       in   cfg_index, cfg_data                             cfg_write_en
//
// One item per cycle unless out_ch stalls: the table RAM is read at the input
// transfer, tag compare and fill happen in the lookup stage, the result register follows.
// After reset a clearing pass writes every table entry invalid, one per cycle,
// during which in_ch.ready is low.
// A stalled output holds the lookup stage; a fill written by one item is
// forwarded to the next if it reads the same entry.
`default_nettype none

module indirect_jump_target_cache #(
  parameter int MAX_INDEX_BITS = ijtc_pkg::MAX_INDEX_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  ijtc_in_if.sink                                  in_ch,
  ijtc_out_if.source                               out_ch,
  input  wire logic                                cfg_write_en,
  input  wire logic [ijtc_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [ijtc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW    = MAX_INDEX_BITS;
  localparam int DEPTH = 1 << MAX_INDEX_BITS;
  localparam int EW    = $bits(ijtc_pkg::entry_t);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  // configuration
  logic [1:0] cache_mode;
  logic [3:0] index_width;
  logic       hash_enable;
  logic [7:0] marker_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_mode  <= ijtc_pkg::RESET_CACHE_MODE;
      index_width <= ijtc_pkg::RESET_INDEX_WIDTH;
      hash_enable <= ijtc_pkg::RESET_HASH_ENABLE;
      marker_byte <= ijtc_pkg::RESET_MARKER_BYTE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ijtc_pkg::REG_CACHE_MODE:  cache_mode  <= cfg_data[1:0];
        ijtc_pkg::REG_INDEX_WIDTH: index_width <= cfg_data[3:0];
        ijtc_pkg::REG_HASH_ENABLE: hash_enable <= cfg_data[0];
        ijtc_pkg::REG_MARKER_BYTE: marker_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic use_table;
  logic counting;
  assign use_table = (cache_mode != ijtc_pkg::MODE_BYPASS);
  assign counting  = cache_mode[1];

  // index computation
  logic [4:0]           used_bits;
  logic [5:0]           hash_shift;
  logic [IW-1:0]        idx_mask;
  logic [31:0]          hash_hi;
  logic [IW-1:0]        in_idx;

  always_comb begin
    if (index_width == 4'd0) begin
      used_bits = 5'd1;
    end else if ({1'b0, index_width} > 5'(IW)) begin
      used_bits = 5'(IW);
    end else begin
      used_bits = {1'b0, index_width};
    end
    hash_shift = 6'd2 + {1'b0, used_bits};
    idx_mask   = ~({IW{1'b1}} << used_bits);
    hash_hi    = in_ch.jump_pc >> hash_shift;
    in_idx     = (in_ch.jump_pc[IW+1:2] ^ (hash_enable ? hash_hi[IW-1:0] : '0)) & idx_mask;
  end

  // clearing pass
  logic          state;
  logic [IW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == {IW{1'b1}}) begin
        state <= ST_RUN;
      end
    end
  end

  // lookup stage
  logic                           s1_valid;
  logic [ijtc_pkg::PC_W-1:0]      s1_pc;
  logic [ijtc_pkg::WORD_W-1:0]    s1_word;
  logic [IW-1:0]                  s1_idx;
  logic                           s1_adv;
  logic                           in_xfer;

  logic                           out_valid;

  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pc   <= in_ch.jump_pc;
      s1_word <= in_ch.memory_word;
      s1_idx  <= in_idx;
    end
  end

  // table RAM
  ijtc_pkg::entry_t ram_rdata;
  ijtc_pkg::entry_t ram_wdata;
  ijtc_pkg::entry_t fill_entry;
  logic [IW-1:0]    ram_waddr;
  logic             ram_we;
  logic             fill_we;
  logic [EW-1:0]    ram_rbits;

  ijtc_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (in_idx),
    .rdata (ram_rbits)
  );

  assign ram_rdata = ram_rbits;

  // last fill, forwarded to a read that raced it
  logic                  fwd_valid;
  logic [IW-1:0]         fwd_idx;
  ijtc_pkg::entry_t      fwd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (fill_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fwd_idx   <= s1_idx;
      fwd_entry <= fill_entry;
    end
  end

  ijtc_pkg::entry_t              entry;
  logic                          hit;
  logic                          marked;
  logic                          found;
  logic [ijtc_pkg::OFFSET_W-1:0] offset;

  always_comb begin
    entry  = (fwd_valid && fwd_idx == s1_idx) ? fwd_entry : ram_rdata;
    hit    = use_table && entry.valid && (entry.tag == s1_pc);
    marked = (s1_word[31:24] == marker_byte);
    found  = hit || marked;
    if (hit) begin
      offset = entry.offset;
    end else if (marked) begin
      offset = s1_word[ijtc_pkg::OFFSET_W-1:0];
    end else begin
      offset = '0;
    end
    fill_we           = s1_adv && use_table && !hit && marked;
    fill_entry.valid  = 1'b1;
    fill_entry.tag    = s1_pc;
    fill_entry.offset = s1_word[ijtc_pkg::OFFSET_W-1:0];
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = fill_we;
      ram_waddr = s1_idx;
      ram_wdata = fill_entry;
    end
  end

  // counters
  logic [ijtc_pkg::COUNT_W-1:0] hit_count;
  logic [ijtc_pkg::COUNT_W-1:0] miss_count;
  logic [ijtc_pkg::COUNT_W-1:0] hit_count_next;
  logic [ijtc_pkg::COUNT_W-1:0] miss_count_next;

  always_comb begin
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (use_table && counting) begin
      if (hit) begin
        if (hit_count != ijtc_pkg::COUNT_MAX) begin
          hit_count_next = hit_count + 1'b1;
        end
      end else if (miss_count != ijtc_pkg::COUNT_MAX) begin
        miss_count_next = miss_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      miss_count <= '0;
    end else if (s1_adv) begin
      hit_count  <= hit_count_next;
      miss_count <= miss_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_ch.table_hit     <= hit;
      out_ch.block_found   <= found;
      out_ch.block_offset  <= offset;
      out_ch.hits_so_far   <= hit_count_next;
      out_ch.misses_so_far <= miss_count_next;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
